// File: design/assert_macros.svh
// Assertion macros used by the reverse grain delay top level.
// Plain text macros with no dependencies; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition and consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed: same-cycle implication");

// Consequence in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: design/rgd_pkg.sv
// Shared constants, register codes and types of the reverse grain delay.
// No dependencies; used by every module of the block but rgd_ram.
package rgd_pkg;

  localparam int DEF_MAX_GRAIN   = 65536;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int MIN_GRAIN       = 256;
  localparam int LEN_RESET       = 4800;

  localparam int CFG_W = 17;
  localparam int IDX_W = 2;
  localparam int FB_W  = 8;
  localparam int MIX_W = 9;

  localparam logic [IDX_W-1:0] REG_GRAIN_LENGTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd1;
  localparam logic [IDX_W-1:0] REG_WET_MIX       = 2'd2;

  localparam logic [FB_W-1:0]  FB_MAX  = 8'd230;
  localparam logic [MIX_W-1:0] MIX_ONE = 9'd256;

  typedef struct packed {
    logic [FB_W-1:0]  fb;
    logic [MIX_W-1:0] mix;
  } gain_t;

endpackage

// File: design/rgd_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module rgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/rgd_ctrl.sv
// Configuration registers, grain position, bank select and grain addressing.
// Depends on rgd_pkg.
module rgd_ctrl #(
  parameter int MAX_GRAIN = rgd_pkg::DEF_MAX_GRAIN,
  localparam int POS_W = $clog2(MAX_GRAIN),
  localparam int AW = POS_W + 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rgd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rgd_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        advance,
  output rgd_pkg::gain_t              gain,
  output logic [AW-1:0]               rd_addr,
  output logic [AW-1:0]               wr_addr,
  output logic                        first_grain
);

  localparam int LEN_W = POS_W + 1;
  localparam int LEN_INIT = (rgd_pkg::LEN_RESET > MAX_GRAIN) ? MAX_GRAIN : rgd_pkg::LEN_RESET;

  logic [LEN_W-1:0] grain_len;
  logic [POS_W-1:0] pos;
  logic             bank;
  logic             first;
  logic [31:0]      data_wide;
  logic [LEN_W-1:0] len_req;
  logic [LEN_W-1:0] pos_inc;
  logic [LEN_W-1:0] rev;
  logic             wrap;
  logic             restart;

  always_comb begin
    data_wide = 32'(cfg_data);
    if (data_wide < 32'(rgd_pkg::MIN_GRAIN)) begin
      len_req = LEN_W'(rgd_pkg::MIN_GRAIN);
    end else if (data_wide > 32'(MAX_GRAIN)) begin
      len_req = LEN_W'(MAX_GRAIN);
    end else begin
      len_req = data_wide[LEN_W-1:0];
    end
  end

  assign restart = cfg_we && (cfg_index == rgd_pkg::REG_GRAIN_LENGTH) &&
                   (len_req != grain_len);
  assign pos_inc = {1'b0, pos} + LEN_W'(1);
  assign wrap    = (pos_inc == grain_len);
  assign rev     = grain_len - LEN_W'(1) - {1'b0, pos};
  assign rd_addr = {~bank, rev[POS_W-1:0]};
  assign wr_addr = {bank, pos};
  assign first_grain = first;

  always_ff @(posedge clk) begin
    if (rst) begin
      grain_len <= LEN_W'(LEN_INIT);
      gain      <= '0;
      pos       <= '0;
      bank      <= 1'b0;
      first     <= 1'b1;
    end else begin
      if (restart) begin
        grain_len <= len_req;
        pos       <= '0;
        bank      <= 1'b0;
        first     <= 1'b1;
      end else if (advance) begin
        if (wrap) begin
          pos   <= '0;
          bank  <= ~bank;
          first <= 1'b0;
        end else begin
          pos <= pos_inc[POS_W-1:0];
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          rgd_pkg::REG_FEEDBACK_GAIN: begin
            gain.fb <= (cfg_data[rgd_pkg::FB_W-1:0] > rgd_pkg::FB_MAX) ?
                       rgd_pkg::FB_MAX : cfg_data[rgd_pkg::FB_W-1:0];
          end
          rgd_pkg::REG_WET_MIX: begin
            gain.mix <= (cfg_data[rgd_pkg::MIX_W-1:0] > rgd_pkg::MIX_ONE) ?
                        rgd_pkg::MIX_ONE : cfg_data[rgd_pkg::MIX_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: design/rgd_pipe.sv
// Sample pipeline: wet read with forwarding, feedback capture, dry/wet blend.
// Depends on rgd_pkg; drives the write port of the grain RAM.
module rgd_pipe #(
  parameter int SAMPLE_BITS = rgd_pkg::DEF_SAMPLE_BITS,
  parameter int AW = 17
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          accept,
  input  logic signed [SAMPLE_BITS-1:0] in_left,
  input  logic signed [SAMPLE_BITS-1:0] in_right,
  input  logic [AW-1:0]                 rd_addr,
  input  logic [AW-1:0]                 wr_addr,
  input  logic                          first_grain,
  input  rgd_pkg::gain_t                gain,
  input  logic [2*SAMPLE_BITS-1:0]      rdata,
  output logic                          we,
  output logic [AW-1:0]                 waddr,
  output logic [2*SAMPLE_BITS-1:0]      wdata,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right
);

  localparam int S      = SAMPLE_BITS;
  localparam int FP_W   = S + 9;
  localparam int MP_W   = S + 10;
  localparam int SUM_W  = S + 11;
  localparam logic signed [FP_W-1:0]  ROUND_FB  = FP_W'(128);
  localparam logic signed [SUM_W-1:0] ROUND_MIX = SUM_W'(128);
  localparam logic signed [SUM_W-1:0] SMAX = {{(SUM_W-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SMIN = {{(SUM_W-S+1){1'b1}}, {(S-1){1'b0}}};

  function automatic logic signed [S-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [S-1:0] r;
    if (v > SMAX) begin
      r = SMAX[S-1:0];
    end else if (v < SMIN) begin
      r = SMIN[S-1:0];
    end else begin
      r = v[S-1:0];
    end
    return r;
  endfunction

  logic                 s1_valid;
  logic signed [S-1:0]  s1_dry_l;
  logic signed [S-1:0]  s1_dry_r;
  logic [AW-1:0]        s1_waddr;
  logic                 s1_first;
  logic                 s1_fwd;
  logic [2*S-1:0]       s1_fwd_data;

  logic signed [S-1:0]    wet_l;
  logic signed [S-1:0]    wet_r;
  logic [2*S-1:0]         wet_raw;
  logic signed [FP_W-1:0] fbprod_l;
  logic signed [FP_W-1:0] fbprod_r;
  logic signed [FP_W-1:0] fbround_l;
  logic signed [FP_W-1:0] fbround_r;
  logic signed [S+1:0]    capsum_l;
  logic signed [S+1:0]    capsum_r;
  logic [rgd_pkg::MIX_W-1:0] mix_inv;

  logic                   s2_valid;
  logic signed [MP_W-1:0] s2_dry_l;
  logic signed [MP_W-1:0] s2_dry_r;
  logic signed [MP_W-1:0] s2_wet_l;
  logic signed [MP_W-1:0] s2_wet_r;

  logic signed [SUM_W-1:0] sum_l;
  logic signed [SUM_W-1:0] sum_r;

  always_comb begin
    wet_raw   = s1_fwd ? s1_fwd_data : rdata;
    wet_l     = s1_first ? '0 : $signed(wet_raw[S-1:0]);
    wet_r     = s1_first ? '0 : $signed(wet_raw[2*S-1:S]);
    fbprod_l  = wet_l * $signed({1'b0, gain.fb});
    fbprod_r  = wet_r * $signed({1'b0, gain.fb});
    fbround_l = fbprod_l + ROUND_FB;
    fbround_r = fbprod_r + ROUND_FB;
    capsum_l  = (S+2)'(s1_dry_l) + (S+2)'(fbround_l >>> 8);
    capsum_r  = (S+2)'(s1_dry_r) + (S+2)'(fbround_r >>> 8);
    mix_inv   = rgd_pkg::MIX_ONE - gain.mix;
  end

  assign we    = s1_valid && en;
  assign waddr = s1_waddr;
  assign wdata = {sat(SUM_W'(capsum_r)), sat(SUM_W'(capsum_l))};

  assign sum_l = SUM_W'(s2_dry_l) + SUM_W'(s2_wet_l) + ROUND_MIX;
  assign sum_r = SUM_W'(s2_dry_r) + SUM_W'(s2_wet_r) + ROUND_MIX;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= accept;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dry_l    <= in_left;
      s1_dry_r    <= in_right;
      s1_waddr    <= wr_addr;
      s1_first    <= first_grain;
      s1_fwd      <= s1_valid && (s1_waddr == rd_addr);
      s1_fwd_data <= wdata;
      s2_dry_l    <= s1_dry_l * $signed({1'b0, mix_inv});
      s2_dry_r    <= s1_dry_r * $signed({1'b0, mix_inv});
      s2_wet_l    <= wet_l * $signed({1'b0, gain.mix});
      s2_wet_r    <= wet_r * $signed({1'b0, gain.mix});
      out_left    <= sat(sum_l >>> 8);
      out_right   <= sat(sum_r >>> 8);
    end
  end

endmodule

// File: design/reverse_grain_delay_top.sv
// Top level of the stereo reverse grain delay.
// Depends on rgd_pkg, rgd_ram, rgd_ctrl, rgd_pipe and assert_macros.svh.
//
// Input beats carry one stereo sample pair (in_left, in_right) and are taken
// when in_valid is high and in_stall is low. Each input beat yields exactly one
// output beat (out_left, out_right) through the s1, s2 and output registers;
// the beat is held while out_stall is high. One beat is accepted every cycle
// unless the pipeline holds; the rate is set by one read and one write per
// cycle on the shared grain RAM, which holds both channels side by side in two
// banks. While the output register is full and stalled, the whole pipeline
// holds and in_stall is raised; it falls in the cycle the output beat is taken.
// The configuration port writes grain_length, feedback_gain or wet_mix at any
// edge with cfg_we high; the user must make writes only while no beat is in
// flight, and the block does not enforce it. Reset and any change of the grain
// length restart at position zero in bank zero, and the first grain after that
// plays silence without clearing, so input beats are accepted right after reset.
`include "assert_macros.svh"

module reverse_grain_delay_top #(
  parameter int MAX_GRAIN   = rgd_pkg::DEF_MAX_GRAIN,
  parameter int SAMPLE_BITS = rgd_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_left,
  input  logic signed [SAMPLE_BITS-1:0] in_right,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  input  logic                          cfg_we,
  input  logic [rgd_pkg::IDX_W-1:0]     cfg_index,
  input  logic [rgd_pkg::CFG_W-1:0]     cfg_data
);

  localparam int POS_W = $clog2(MAX_GRAIN);
  localparam int AW    = POS_W + 1;
  localparam int DEPTH = 2 << POS_W;

  logic                     en;
  logic                     rd_en;
  rgd_pkg::gain_t           gain;
  logic [AW-1:0]            ram_raddr;
  logic [AW-1:0]            wr_addr;
  logic                     first_grain;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [2*SAMPLE_BITS-1:0] ram_wdata;
  logic [2*SAMPLE_BITS-1:0] ram_rdata;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign rd_en    = in_valid && en;

  rgd_ctrl #(
    .MAX_GRAIN(MAX_GRAIN)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .advance    (rd_en),
    .gain       (gain),
    .rd_addr    (ram_raddr),
    .wr_addr    (wr_addr),
    .first_grain(first_grain)
  );

  rgd_ram #(
    .WIDTH(2*SAMPLE_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (rd_en),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  rgd_pipe #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .AW         (AW)
  ) u_pipe (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .accept     (rd_en),
    .in_left    (in_left),
    .in_right   (in_right),
    .rd_addr    (ram_raddr),
    .wr_addr    (wr_addr),
    .first_grain(first_grain),
    .gain       (gain),
    .rdata      (ram_rdata),
    .we         (ram_we),
    .waddr      (ram_waddr),
    .wdata      (ram_wdata),
    .out_valid  (out_valid),
    .out_left   (out_left),
    .out_right  (out_right)
  );

  // A read and a write in the same bank collide only at a bank swap, on the same entry.
  `ASSERT_IMPLIES(a_swap_same_entry, clk, rst, ram_we && rd_en && (ram_waddr[AW-1] == ram_raddr[AW-1]), ram_waddr == ram_raddr)
  `ASSERT_NEXT(a_write_follows_read, clk, rst, rd_en, ram_we || (out_valid && out_stall))
  `ASSERT_IMPLIES(a_no_write_when_held, clk, rst, ram_we, !(out_valid && out_stall))

endmodule

// File: test/reverse_grain_delay_top_tb.sv
// Self-checking testbench for reverse_grain_delay_top, the stereo reverse grain delay.
// Depends on rgd_pkg and the block's RTL; an in-bench predictor models the grain banks.
// Stimulus runs through several register settings, with random sender gaps and output stalls.
module reverse_grain_delay_top_tb;

  localparam int MAXG = rgd_pkg::DEF_MAX_GRAIN;
  localparam int LIMIT = 400000;
  localparam logic [rgd_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } pair_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_left = '0;
  logic signed [15:0] in_right = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;
  logic cfg_we = 1'b0;
  logic [rgd_pkg::IDX_W-1:0] cfg_index = '0;
  logic [rgd_pkg::CFG_W-1:0] cfg_data = '0;

  reverse_grain_delay_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_left(in_left), .in_right(in_right),
    .out_valid(out_valid), .out_stall(out_stall), .out_left(out_left), .out_right(out_right),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: two banks per channel, play position and capture bank.
  logic signed [15:0] grain_store [2][2*MAXG];
  int unsigned len_in_use;
  int unsigned play_pos;
  logic cap_bank;
  int unsigned fb_setting;
  int unsigned mix_setting;

  pair_t sample_queue [$];
  pair_t blend_queue [$];
  pair_t next_beat;
  pair_t want;
  int beats_in = 0;
  int beats_out = 0;
  int errors = 0;
  int cycles = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_span = 0;
  stall_mode_t stall_mode = STALL_NONE;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic void clear_grains();
    foreach (grain_store[c, a]) grain_store[c][a] = '0;
    play_pos = 0;
    cap_bank = 1'b0;
  endfunction

  function automatic pair_t predict_blend(pair_t s);
    int unsigned p, rd, wr;
    longint fbg, mixg, fbterm, mix_one;
    longint dry[2], wet[2];
    logic signed [15:0] res[2];
    pair_t r;
    p = play_pos;
    if (p >= len_in_use) p = 0;
    wr = (cap_bank ? MAXG : 0) + p;
    rd = (cap_bank ? 0 : MAXG) + len_in_use - 1 - p;
    mix_one = longint'(rgd_pkg::MIX_ONE);
    fbg = (fb_setting > rgd_pkg::FB_MAX) ? rgd_pkg::FB_MAX : fb_setting;
    mixg = (mix_setting > rgd_pkg::MIX_ONE) ? rgd_pkg::MIX_ONE : mix_setting;
    dry[0] = $signed(s.left);
    dry[1] = $signed(s.right);
    for (int ch = 0; ch < 2; ch++) begin
      wet[ch] = grain_store[ch][rd];
      fbterm = (wet[ch] * fbg + 128) >>> 8;
      grain_store[ch][wr] = sat16(dry[ch] + fbterm);
      res[ch] = sat16((dry[ch] * (mix_one - mixg) + wet[ch] * mixg + 128) >>> 8);
    end
    play_pos = p + 1;
    if (play_pos >= len_in_use) begin
      play_pos = 0;
      cap_bank = ~cap_bank;
    end
    r.left = res[0];
    r.right = res[1];
    return r;
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_pair(logic signed [15:0] l, logic signed [15:0] r);
    sample_queue.push_back({l, r});
    beats_in++;
  endtask

  task automatic drain();
    while (beats_out != beats_in) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [rgd_pkg::IDX_W-1:0] idx, logic [rgd_pkg::CFG_W-1:0] val);
    int unsigned n;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rgd_pkg::REG_GRAIN_LENGTH: begin
        n = (val < rgd_pkg::MIN_GRAIN) ? rgd_pkg::MIN_GRAIN : (val > MAXG) ? MAXG : val;
        if (n != len_in_use) begin
          len_in_use = n;
          clear_grains();
        end
      end
      rgd_pkg::REG_FEEDBACK_GAIN: fb_setting = val[rgd_pkg::FB_W-1:0];
      rgd_pkg::REG_WET_MIX: mix_setting = val[rgd_pkg::MIX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic play_random(int n);
    repeat (n) push_pair(pick_sample(), pick_sample());
    drain();
  endtask

  // Sender: bursts of beats with random gaps; a stalled beat is held as is.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) blend_queue.push_back(predict_blend({in_left, in_right}));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          next_beat = sample_queue.pop_front();
          in_left <= next_beat.left;
          in_right <= next_beat.right;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 32);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall pattern whose mode changes at random intervals.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_span = $urandom_range(50, 300);
      stall_mode = stall_mode_t'($urandom_range(0, 3));
    end
    stall_span--;
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (cycles % 8 < 3);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      beats_out++;
      if (blend_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, out_left %0d out_right %0d", $time, out_left, out_right);
      end else begin
        want = blend_queue.pop_front();
        if (out_left !== want.left) begin
          errors++;
          $display("%0t: out_left expected %0d actual %0d", $time, want.left, out_left);
        end
        if (out_right !== want.right) begin
          errors++;
          $display("%0t: out_right expected %0d actual %0d", $time, want.right, out_right);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("reverse_grain_delay_top_tb: errors");
      $finish;
    end
  end

  initial begin
    len_in_use = rgd_pkg::LEN_RESET;
    fb_setting = 0;
    mix_setting = 0;
    clear_grains();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: the output is the dry beat.
    push_pair(16'sh0000, 16'sh0000);
    push_pair(16'sh7FFF, 16'sh8000);
    push_pair(16'sh8000, 16'sh7FFF);
    push_pair(16'shFFFF, 16'sh0001);
    push_pair(16'sh0001, 16'shFFFF);
    push_pair(16'sh5555, 16'shAAAA);
    push_pair(16'shAAAA, 16'sh5555);
    drain();

    // Out-of-range values on every register, and a write to an unused index.
    write_reg(rgd_pkg::REG_GRAIN_LENGTH, 17'd0);
    write_reg(rgd_pkg::REG_FEEDBACK_GAIN, 17'd255);
    write_reg(rgd_pkg::REG_WET_MIX, 17'd511);
    write_reg(REG_UNUSED, 17'h1FFFF);
    push_pair(16'sh7FFF, 16'sh7FFF);
    push_pair(16'sh8000, 16'sh8000);
    push_pair(16'sh0000, 16'shFFFF);
    push_pair(16'sh4000, 16'shC000);
    push_pair(16'sh7FFF, 16'sh8000);
    push_pair(16'sh0001, 16'sh0001);
    push_pair(16'shFFFF, 16'shFFFF);
    push_pair(16'sh8000, 16'sh7FFF);
    drain();

    // Same clamped length keeps the stored grain.
    write_reg(rgd_pkg::REG_GRAIN_LENGTH, 17'd256);
    write_reg(rgd_pkg::REG_FEEDBACK_GAIN, 17'($urandom_range(0, 255)));
    write_reg(rgd_pkg::REG_WET_MIX, 17'($urandom_range(0, 511)));
    play_random(400);

    write_reg(rgd_pkg::REG_GRAIN_LENGTH, 17'd255);
    write_reg(rgd_pkg::REG_FEEDBACK_GAIN, 17'd230);
    write_reg(rgd_pkg::REG_WET_MIX, 17'd256);
    play_random(300);

    write_reg(rgd_pkg::REG_GRAIN_LENGTH, 17'd300);
    write_reg(rgd_pkg::REG_FEEDBACK_GAIN, 17'($urandom_range(0, 255)));
    write_reg(rgd_pkg::REG_WET_MIX, 17'd128);
    play_random(350);

    write_reg(rgd_pkg::REG_GRAIN_LENGTH, 17'h1FFFF);
    write_reg(rgd_pkg::REG_FEEDBACK_GAIN, 17'd0);
    write_reg(rgd_pkg::REG_WET_MIX, 17'd256);
    play_random(100);

    write_reg(rgd_pkg::REG_GRAIN_LENGTH, 17'd65537);
    write_reg(REG_UNUSED, 17'd0);
    play_random(50);

    write_reg(rgd_pkg::REG_GRAIN_LENGTH, 17'd257);
    write_reg(rgd_pkg::REG_FEEDBACK_GAIN, 17'd231);
    write_reg(rgd_pkg::REG_WET_MIX, 17'd257);
    play_random(400);

    write_reg(rgd_pkg::REG_GRAIN_LENGTH, 17'd256);
    write_reg(rgd_pkg::REG_FEEDBACK_GAIN, 17'($urandom_range(0, 255)));
    write_reg(rgd_pkg::REG_WET_MIX, 17'($urandom_range(0, 511)));
    play_random(350);

    if (errors == 0) begin
      $display("reverse_grain_delay_top_tb: clean");
    end else begin
      $display("reverse_grain_delay_top_tb: errors");
    end
    $finish;
  end
endmodule
